>>> design/size_class_slab_allocator_assert.svh
// Assertion macros for the slab allocator checker
`ifndef SIZE_CLASS_SLAB_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_SLAB_ALLOCATOR_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define SCSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");
// Next-cycle implication
`define SCSA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");
`endif

>>> design/scsa_pkg.sv
// ----------------------------------------------------------------------------
// scsa_pkg
// Shared types and constants for the size class slab allocator.
// ----------------------------------------------------------------------------
package scsa_pkg;

  localparam int unsigned REGION_BYTES_DEF = 65536;
  localparam int unsigned BLOCK_BYTES_DEF  = 4096;
  localparam int unsigned NUM_CLASSES_DEF  = 64;

  localparam logic [15:0] MAX_SMALL    = 16'd512;
  localparam logic [31:0] HEADER_BYTES = 32'd8;

  // Register indexes
  localparam logic [0:0] REG_BASE   = 1'b0;
  localparam logic [0:0] REG_BLOCKS = 1'b1;

  // Actions
  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NULL    = 3'd1;
  localparam logic [2:0] ST_LARGE   = 3'd2;
  localparam logic [2:0] ST_OOM     = 3'd3;
  localparam logic [2:0] ST_OUTSIDE = 3'd4;

  typedef struct packed {
    logic        action;
    logic [15:0] request_size;
    logic [31:0] release_address;
  } in_word_t;

  typedef struct packed {
    logic [31:0] granted_address;
    logic [2:0]  status;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP,
    S_REM,
    S_FINISH,
    S_OUT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch the input word
    logic decode;    // read class tables, classify
    logic pop_rd;    // issue link read for pop
    logic rem_start; // start the padding remainder
    logic execute;   // update state, build result
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pop;       // allocation pops a free list
    logic fresh;     // allocation takes a new block
    logic rem_done;  // padding remainder ready
  } dp_stat_t;

endpackage

>>> design/scsa_datapath.sv
// ----------------------------------------------------------------------------
// scsa_datapath
// Class tables, link memory, block bump logic and result formation.
// ----------------------------------------------------------------------------
module scsa_datapath #(
  parameter int unsigned REGION_BYTES = scsa_pkg::REGION_BYTES_DEF,
  parameter int unsigned BLOCK_BYTES  = scsa_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned NUM_CLASSES  = scsa_pkg::NUM_CLASSES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_idx,
  input  logic [31:0]         cfg_data,
  input  scsa_pkg::in_word_t  in_word,
  input  scsa_pkg::dp_cmd_t   cmd,
  output scsa_pkg::dp_stat_t  stat,
  output scsa_pkg::out_word_t res_word
);

  localparam int unsigned LINK_DEPTH = REGION_BYTES / 8;
  localparam int unsigned LW  = $clog2(LINK_DEPTH);
  localparam int unsigned OW  = $clog2(REGION_BYTES) + 1;  // offset width incl. slack
  localparam int unsigned CW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned CAP = REGION_BYTES / BLOCK_BYTES;
  localparam int unsigned BW  = $clog2(CAP + 1);
  localparam int unsigned CNW = $clog2(OW + 1);

  // Configuration
  logic [31:0] base_r;
  logic [4:0]  blocks_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      blocks_r <= 5'd16;
    end else if (cfg_we) begin
      if (cfg_idx == scsa_pkg::REG_BASE) base_r <= cfg_data;
      else                               blocks_r <= cfg_data[4:0];
    end
  end

  // Usable block count
  logic [BW-1:0] usable;
  always_comb begin
    if (32'(blocks_r) < 32'(CAP)) usable = BW'(blocks_r);
    else                          usable = BW'(CAP);
  end

  // Latched request
  scsa_pkg::in_word_t req_r;
  always_ff @(posedge clk) begin
    if (cmd.capture) req_r <= in_word;
  end

  // Class decode
  logic [9:0]  cls_wide;
  logic [CW-1:0] cls;
  logic [9:0]  slot;
  assign cls_wide = 10'((17'(req_r.request_size) + 17'd7) >> 3) - 10'd1;
  assign cls      = CW'(cls_wide);
  assign slot     = (cls_wide + 10'd1) << 3;

  logic [31:0] roff;
  assign roff = req_r.release_address - base_r;

  // Class tables; held_r marks a class that owns a bump block
  logic [NUM_CLASSES-1:0] head_vld_r;
  logic [NUM_CLASSES-1:0] held_r;
  logic [OW-1:0] head_r [NUM_CLASSES];
  logic [OW-1:0] next_r [NUM_CLASSES];
  logic [OW-1:0] lim_r  [NUM_CLASSES];
  logic [BW-1:0] taken_r;

  // Link memory: valid flag plus offset
  logic [OW:0] link_mem [LINK_DEPTH];
  logic [OW:0] link_q_r;

  // Decoded values for the execute step
  logic [2:0]    early_st_r;
  logic          early_r;
  logic          pop_r;
  logic          hv_r;
  logic          held_q_r;
  logic [OW-1:0] head_q_r, next_raw_r, lim_raw_r;
  logic [CW-1:0] cls_r;
  logic [9:0]    slot_r;

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      cls_r      <= cls;
      slot_r     <= slot;
      hv_r       <= head_vld_r[cls];
      held_q_r   <= held_r[cls];
      head_q_r   <= head_r[cls];
      next_raw_r <= next_r[cls];
      lim_raw_r  <= lim_r[cls];
      early_r    <= 1'b1;
      pop_r      <= 1'b0;
      if (req_r.request_size == '0 ||
          (req_r.action == scsa_pkg::ACT_RELEASE && req_r.release_address == '0)) begin
        early_st_r <= scsa_pkg::ST_NULL;
      end else if (req_r.request_size > scsa_pkg::MAX_SMALL ||
                   32'(cls_wide) >= 32'(NUM_CLASSES)) begin
        early_st_r <= scsa_pkg::ST_LARGE;
      end else if (req_r.action == scsa_pkg::ACT_RELEASE &&
                   {1'b0, roff} >= 33'(usable) * 33'(BLOCK_BYTES)) begin
        early_st_r <= scsa_pkg::ST_OUTSIDE;
      end else begin
        early_r    <= 1'b0;
        early_st_r <= scsa_pkg::ST_OK;
        pop_r      <= (req_r.action == scsa_pkg::ACT_ALLOC) && head_vld_r[cls];
      end
    end
  end

  // A class without a block bumps from zero up to zero: no slot left
  logic [OW-1:0] next_q, lim_q;
  assign next_q = held_q_r ? next_raw_r : '0;
  assign lim_q  = held_q_r ? lim_raw_r  : '0;

  // Classify the allocate path
  logic alloc_ok, fits, room;
  assign alloc_ok = !early_r && req_r.action == scsa_pkg::ACT_ALLOC && !pop_r;
  assign fits     = next_q < lim_q;
  assign room     = taken_r < usable;

  assign stat.pop      = pop_r;
  assign stat.fresh    = alloc_ok && !fits && room;

  // Link read for pop, registered
  always_ff @(posedge clk) begin
    if (cmd.pop_rd) link_q_r <= link_mem[head_q_r[3 +: LW]];
  end

  // New block placement
  logic [OW-1:0] blk, body, off_new, lim_new;
  logic [OW-1:0] slot_w;
  assign slot_w  = OW'(slot_r);
  assign blk     = OW'(taken_r) * OW'(BLOCK_BYTES);
  assign body    = blk + OW'(scsa_pkg::HEADER_BYTES);

  // Remainder of the block body by the slot size, one dividend bit per cycle
  logic [OW-1:0]  rem_r, dvd_r;
  logic [OW:0]    rem_try, rem_sub;
  logic [CNW-1:0] rem_cnt_r;
  assign rem_try = {rem_r, dvd_r[OW-1]};
  assign rem_sub = rem_try - {1'b0, slot_w};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r     <= '0;
      dvd_r     <= '0;
      rem_cnt_r <= '0;
    end else if (cmd.rem_start) begin
      rem_r     <= '0;
      dvd_r     <= body;
      rem_cnt_r <= CNW'(OW);
    end else if (rem_cnt_r != '0) begin
      rem_r     <= (rem_try >= {1'b0, slot_w}) ? rem_sub[OW-1:0] : rem_try[OW-1:0];
      dvd_r     <= {dvd_r[OW-2:0], 1'b0};
      rem_cnt_r <= rem_cnt_r - CNW'(1);
    end
  end

  assign stat.rem_done = (rem_cnt_r == '0);

  assign off_new = (rem_r == '0) ? body : body + (slot_w - rem_r);
  assign lim_new = blk + OW'(BLOCK_BYTES) - slot_w + OW'(1);

  // Execute decisions
  logic go, do_rel, do_pop, do_bump, do_new, do_oom;
  assign go      = cmd.execute && !early_r;
  assign do_rel  = go && req_r.action == scsa_pkg::ACT_RELEASE;
  assign do_pop  = go && req_r.action == scsa_pkg::ACT_ALLOC && pop_r;
  assign do_bump = cmd.execute && alloc_ok && fits;
  assign do_new  = cmd.execute && alloc_ok && !fits && room;
  assign do_oom  = cmd.execute && alloc_ok && !fits && !room;

  // Update the table memories
  always_ff @(posedge clk) begin
    if (do_rel) link_mem[roff[3 +: LW]] <= {hv_r, head_q_r};
    if (do_rel)      head_r[cls_r] <= OW'(roff);
    else if (do_pop) head_r[cls_r] <= link_q_r[OW-1:0];
    if (do_bump)     next_r[cls_r] <= next_q + slot_w;
    else if (do_new) next_r[cls_r] <= off_new + slot_w;
    if (do_new)      lim_r[cls_r]  <= lim_new;
  end

  // Update list and block flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= '0;
      held_r     <= '0;
      taken_r    <= '0;
    end else begin
      if (do_rel)      head_vld_r[cls_r] <= 1'b1;
      else if (do_pop) head_vld_r[cls_r] <= link_q_r[OW];
      if (do_new) begin
        held_r[cls_r] <= 1'b1;
        taken_r       <= taken_r + BW'(1);
      end
    end
  end

  // Form the result
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      res_word.status <= do_oom ? scsa_pkg::ST_OOM : early_st_r;
      if (do_pop)       res_word.granted_address <= base_r + 32'(head_q_r);
      else if (do_bump) res_word.granted_address <= base_r + 32'(next_q);
      else if (do_new)  res_word.granted_address <= base_r + 32'(off_new);
      else              res_word.granted_address <= '0;
    end
  end

endmodule

>>> design/scsa_ctrl.sv
// ----------------------------------------------------------------------------
// scsa_ctrl
// Request sequencer: capture, decode, optional link read, optional padding remainder, execute, hand off.
// ----------------------------------------------------------------------------
module scsa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  scsa_pkg::dp_stat_t stat,
  output scsa_pkg::dp_cmd_t  cmd
);

  scsa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= scsa_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      scsa_pkg::S_IDLE:   if (in_valid) state_nxt = scsa_pkg::S_DECODE;
      scsa_pkg::S_DECODE: state_nxt = scsa_pkg::S_POP;
      scsa_pkg::S_POP:    state_nxt = stat.fresh ? scsa_pkg::S_REM : scsa_pkg::S_FINISH;
      scsa_pkg::S_REM:    if (stat.rem_done) state_nxt = scsa_pkg::S_FINISH;
      scsa_pkg::S_FINISH: state_nxt = scsa_pkg::S_OUT;
      scsa_pkg::S_OUT: begin
        if (out_ready) state_nxt = in_valid ? scsa_pkg::S_DECODE : scsa_pkg::S_IDLE;
      end
      default:            state_nxt = scsa_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      scsa_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      scsa_pkg::S_DECODE: cmd.decode = 1'b1;
      scsa_pkg::S_POP: begin
        cmd.pop_rd    = stat.pop;
        cmd.rem_start = stat.fresh;
      end
      scsa_pkg::S_REM:    ;
      scsa_pkg::S_FINISH: cmd.execute = 1'b1;
      scsa_pkg::S_OUT: begin
        out_valid    = 1'b1;
        in_ready     = out_ready;
        cmd.capture  = out_ready && in_valid;
      end
      default: ;
    endcase
  end

endmodule

>>> design/size_class_slab_allocator.sv
// ----------------------------------------------------------------------------
// size_class_slab_allocator
// Segregated free-list allocator with per-class bump blocks.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : valid/ready word {action, request_size, release_address}.
//   out channel : valid/ready word {granted_address, status}, one per request.
//   cfg port    : cfg_we/cfg_idx/cfg_data, write region_base (0) or
//                 region_blocks (1) only while idle.
// Sequence: capture, decode, link read and execute steps, then out_valid.
//   An allocate that takes a new block adds a bit-serial padding remainder
//   step between the link read and execute steps.
// Flow: one request at a time; a new word is taken in the cycle its
//   predecessor's result is taken.
// Reset: all free lists empty, no blocks held, region_base 0,
//   region_blocks 16. Link memory content is undefined until written.
// Stall: the result holds on out while out_ready is low, and no new word
//   is accepted until it is taken.
// ----------------------------------------------------------------------------
module size_class_slab_allocator #(
  parameter int unsigned REGION_BYTES = scsa_pkg::REGION_BYTES_DEF,
  parameter int unsigned BLOCK_BYTES  = scsa_pkg::BLOCK_BYTES_DEF,
  parameter int unsigned NUM_CLASSES  = scsa_pkg::NUM_CLASSES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  scsa_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output scsa_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_idx,
  input  logic [31:0]         cfg_data
);

  scsa_pkg::dp_cmd_t  cmd;
  scsa_pkg::dp_stat_t stat;

  scsa_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .stat, .cmd
  );

  scsa_datapath #(
    .REGION_BYTES(REGION_BYTES), .BLOCK_BYTES(BLOCK_BYTES), .NUM_CLASSES(NUM_CLASSES)
  ) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data,
    .in_word(in_data), .cmd, .stat, .res_word(out_data)
  );

endmodule

>>> design/scsa_checker.sv
// ----------------------------------------------------------------------------
// scsa_checker
// Port-level checks for the slab allocator.
// ----------------------------------------------------------------------------
`include "size_class_slab_allocator_assert.svh"
module scsa_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input scsa_pkg::out_word_t out_data
);
  // No accept while a result waits unseen
  `SCSA_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid && !out_ready, !in_ready)
  // Result holds while stalled
  `SCSA_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  // Failed request never grants an address
  `SCSA_ASSERT_IMP(a_zero_on_err, clk, rst_n,
    out_valid && out_data.status != scsa_pkg::ST_OK, out_data.granted_address == '0)
  // Status stays in its code range
  `SCSA_ASSERT_IMP(a_status_rng, clk, rst_n, out_valid, out_data.status <= scsa_pkg::ST_OUTSIDE)
endmodule

bind size_class_slab_allocator scsa_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);

>>> tb/sv/size_class_slab_allocator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// size_class_slab_allocator_test
// Self-checking bench: drives allocate and release words with random gaps,
// predicts every result with a cycle-free model of the free lists and bump
// blocks, and compares each result word against the oldest prediction.
// ----------------------------------------------------------------------------

class slab_scoreboard;
  logic [31:0] base_addr;
  logic [4:0]  num_blocks;
  logic [31:0] head_tab [64];
  logic [31:0] bump_ptr [64];
  logic [31:0] bump_end [64];
  logic [31:0] taken;
  logic [31:0] links [8192];
  scsa_pkg::out_word_t awaited [$];
  scsa_pkg::out_word_t last_want;
  int          errors;
  int          matched;
  int          oom_seen;
  int          pops_seen;

  function new();
    base_addr  = 32'd0;
    num_blocks = 5'd16;
    taken      = 32'd0;
    errors     = 0;
    matched    = 0;
    oom_seen   = 0;
    pops_seen  = 0;
    for (int i = 0; i < 64; i++) begin
      head_tab[i] = 32'd0;
      bump_ptr[i] = 32'd0;
      bump_end[i] = 32'd0;
    end
  endfunction

  function void set_reg(logic [0:0] idx, logic [31:0] val);
    if (idx == scsa_pkg::REG_BASE) base_addr = val;
    else num_blocks = val[4:0];
  endfunction

  // Work out the result of one accepted request and advance the state
  function scsa_pkg::out_word_t grant_for(scsa_pkg::in_word_t w);
    scsa_pkg::out_word_t r;
    logic [31:0] usable, cls, slot, off, blk, body, pad;
    r.granted_address = 32'd0;
    r.status = scsa_pkg::ST_OK;
    usable = (num_blocks < 5'd16) ? {27'd0, num_blocks} : 32'd16;
    if (w.request_size == 16'd0 ||
        (w.action == scsa_pkg::ACT_RELEASE && w.release_address == 0)) begin
      r.status = scsa_pkg::ST_NULL;
      return r;
    end
    if (w.request_size > scsa_pkg::MAX_SMALL) begin
      r.status = scsa_pkg::ST_LARGE;
      return r;
    end
    cls  = ((32'(w.request_size) + 32'd7) >> 3) - 32'd1;
    slot = (cls + 32'd1) << 3;
    if (w.action == scsa_pkg::ACT_RELEASE) begin
      off = w.release_address - base_addr;
      if (off >= usable * 32'd4096) begin
        r.status = scsa_pkg::ST_OUTSIDE;
        return r;
      end
      links[off[15:3]] = head_tab[cls];
      head_tab[cls] = {1'b1, off[30:0]};
      return r;
    end
    // Pop the free list first
    if (head_tab[cls][31]) begin
      off = {1'b0, head_tab[cls][30:0]};
      head_tab[cls] = links[off[15:3]];
      r.granted_address = base_addr + off;
      pops_seen++;
      return r;
    end
    // Bump, taking a fresh block when the current one is spent
    if (bump_ptr[cls] >= bump_end[cls]) begin
      if (taken >= usable) begin
        r.status = scsa_pkg::ST_OOM;
        oom_seen++;
        return r;
      end
      blk = taken * 32'd4096;
      taken++;
      body = blk + scsa_pkg::HEADER_BYTES;
      pad = (slot - (body % slot)) % slot;
      off = body + pad;
      bump_end[cls] = blk + 32'd4096 - slot + 32'd1;
    end else begin
      off = bump_ptr[cls];
    end
    bump_ptr[cls] = off + slot;
    r.granted_address = base_addr + off;
    return r;
  endfunction

  function void note_request(scsa_pkg::in_word_t w);
    last_want = grant_for(w);
    awaited.push_back(last_want);
  endfunction

  function void check_result(scsa_pkg::out_word_t got);
    scsa_pkg::out_word_t want;
    if (awaited.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result word addr=%h st=%0d",
                                 got.granted_address, got.status);
      return;
    end
    want = awaited.pop_front();
    if (got.granted_address !== want.granted_address || got.status !== want.status) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: expected addr=%h st=%0d, got addr=%h st=%0d",
                 want.granted_address, want.status, got.granted_address, got.status);
    end else begin
      matched++;
    end
  endfunction

  function int pending();
    return awaited.size();
  endfunction
endclass

module size_class_slab_allocator_test;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [31:0] addr;
    logic [15:0] size;
  } live_slot_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  scsa_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  scsa_pkg::out_word_t out_data;
  logic                cfg_we = 1'b0;
  logic [0:0]          cfg_idx = scsa_pkg::REG_BASE;
  logic [31:0]         cfg_data = 32'd0;

  slab_scoreboard sb = new();
  live_slot_t     live_slots [$];
  int             cycles = 0;
  bit             calm = 1'b0;
  bit             hold_req = 1'b0;

  size_class_slab_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Check results at the edge and keep the watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Receiver: random stalls, a long hold-off on request
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= (calm || $urandom_range(99) >= 27);
        @(posedge clk);
      end
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Offer one word, hold it until taken, then note it
  task automatic send_word(scsa_pkg::in_word_t w);
    int gap;
    if (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(w);
  endtask

  task automatic send_req(logic act, logic [15:0] size, logic [31:0] addr);
    scsa_pkg::in_word_t w;
    w.action = act;
    w.request_size = size;
    w.release_address = addr;
    send_word(w);
  endtask

  // Let everything drain, then let the sequencer idle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Mostly allocate or release live slots; the rest is noise
  task automatic random_word();
    int          pick, k;
    logic [15:0] sz;
    live_slot_t  s;
    pick = $urandom_range(99);
    if (pick < 10) begin
      send_req(1'($urandom), 16'($urandom), $urandom);
    end else if (pick < 14) begin
      send_req(1'($urandom), 16'd0, $urandom);
    end else if (pick < 17) begin
      send_req(scsa_pkg::ACT_RELEASE, 16'($urandom_range(1, 512)), 32'd0);
    end else if (pick < 50 && live_slots.size() > 0) begin
      k = $urandom_range(live_slots.size() - 1);
      s = live_slots[k];
      live_slots.delete(k);
      // Any size mapping to the same class
      sz = ((s.size + 16'd7) & ~16'd7) - 16'($urandom_range(0, 7));
      if (sz == 0) sz = 16'd1;
      send_req(scsa_pkg::ACT_RELEASE, sz, s.addr);
    end else begin
      sz = ($urandom_range(3) == 0) ? 16'($urandom_range(1, 512))
                                    : 16'($urandom_range(1, 64));
      send_req(scsa_pkg::ACT_ALLOC, sz, $urandom);
      // Remember what the model grants so it can be released later
      if (sb.last_want.status == scsa_pkg::ST_OK && live_slots.size() < 200) begin
        s.addr = sb.last_want.granted_address;
        s.size = sz;
        live_slots.push_back(s);
      end
    end
  endtask

  task automatic run_phase(logic [31:0] base, logic [4:0] blocks, int count);
    drain();
    write_reg(scsa_pkg::REG_BASE, base);
    write_reg(scsa_pkg::REG_BLOCKS, {27'd0, blocks});
    live_slots.delete();
    for (int i = 0; i < count; i++) begin
      calm = (i >= 100 && i < 180);
      if (i == 250) hold_req = 1'b1;
      if (i == 320) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      random_word();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_reg(scsa_pkg::REG_BASE, 32'd0);
    write_reg(scsa_pkg::REG_BLOCKS, 32'd16);

    // Directed: field extremes, null, large and outside statuses, and free-list pops
    send_req(scsa_pkg::ACT_ALLOC, 16'd1, 32'd0);
    send_req(scsa_pkg::ACT_ALLOC, 16'd8, 32'hFFFF_FFFF);
    send_req(scsa_pkg::ACT_ALLOC, 16'd9, 32'd0);
    send_req(scsa_pkg::ACT_ALLOC, 16'd512, 32'd0);
    send_req(scsa_pkg::ACT_ALLOC, 16'd513, 32'd0);
    send_req(scsa_pkg::ACT_ALLOC, 16'hFFFF, 32'd0);
    send_req(scsa_pkg::ACT_ALLOC, 16'd0, 32'd0);
    send_req(scsa_pkg::ACT_RELEASE, 16'd0, 32'h0000_0040);
    send_req(scsa_pkg::ACT_RELEASE, 16'd8, 32'd0);
    send_req(scsa_pkg::ACT_RELEASE, 16'd8, 32'hFFFF_FFFF);
    send_req(scsa_pkg::ACT_RELEASE, 16'hFFFF, 32'h0000_1000);
    send_req(scsa_pkg::ACT_RELEASE, 16'd8, 32'h0000_2008);
    send_req(scsa_pkg::ACT_RELEASE, 16'd8, 32'h0000_2008);
    send_req(scsa_pkg::ACT_ALLOC, 16'd5, 32'd0);
    send_req(scsa_pkg::ACT_ALLOC, 16'd5, 32'd0);
    send_req(scsa_pkg::ACT_RELEASE, 16'd512, 32'h0000_0003);
    send_req(scsa_pkg::ACT_ALLOC, 16'd512, 32'd0);
    send_req(scsa_pkg::ACT_ALLOC, 16'd512, 32'd0);
    send_req(scsa_pkg::ACT_ALLOC, 16'd511, 32'd0);

    // Random phases across region settings, extremes included
    run_phase(32'h0000_0000, 5'd16, 430);
    run_phase(32'hFFFF_F000, 5'd1, 430);
    run_phase(32'h1234_5000, 5'd7, 430);
    run_phase(32'h8000_0000, 5'd16, 430);

    drain();
    $display("covered %0d results: %0d free-list pops, %0d out-of-memory, four region settings",
             sb.matched, sb.pops_seen, sb.oom_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Verification failed");
    end
    $finish;
  end
endmodule
